[sv/ils_pkg.sv]
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int DATA_W   = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Request to the value memory: one write and one read port
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

[sv/indexed_list_store.sv]
// Top level of the indexed list store: sequencer, count and result register.
//
//  channel | dir | handshake               | tdata / tuser
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: item_value, position; tuser: op
//  m_axis  | out | m_axis_tvalid/tready    | tdata: read_value, entry_count; tuser: ok
//
// One word at a time is worked on; a new word is taken only from the idle state.
// Append, failures and unknown ops go from idle straight to the done state; a read
// passes through the read-wait state (one memory read); a remove walks any entries
// after position, one entry moved per cycle through the single memory port pair.
// Reset clears the count and the control state only; the memory needs no clearing.
// A result waiting on m_axis does not block the next input word; a second result
// holds in the done state until the output register frees up.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] item_value, [41:32] position, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] read_value, [42:32] entry_count, rest zero
    output logic [0:0]  m_axis_tuser    // [0] ok
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              res_ok_reg, res_ok_next;
    logic [DATA_W-1:0] res_val_reg, res_val_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [DATA_W-1:0] out_val_reg, out_val_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    mem_req_t          req;
    logic [DATA_W-1:0] rdata;

    logic [1:0]        in_op;
    logic [DATA_W-1:0] in_val;
    logic [IDX_W-1:0]  in_pos;
    logic              s_fire;
    logic              pos_ok;

    ils_mem u_mem (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_op  = s_axis_tuser;
    assign in_val = s_axis_tdata[31:0];
    assign in_pos = s_axis_tdata[41:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign pos_ok        = ({1'b0, in_pos} < count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        res_ok_next  = res_ok_reg;
        res_val_next = res_val_reg;
        out_ok_next  = out_ok_reg;
        out_val_next = out_val_reg;
        out_cnt_next = out_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        req.we    = 1'b0;
        req.waddr = count_reg[IDX_W-1:0];
        req.wdata = in_val;
        req.re    = 1'b0;
        req.raddr = in_pos;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    res_ok_next  = 1'b0;
                    res_val_next = '0;
                    state_next   = ST_DONE;
                    case (in_op)
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                req.we      = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                if (({1'b0, in_pos} + CNT_W'(1)) < count_reg)
                                begin
                                    // start the move-up walk at the entry after position
                                    req.re     = 1'b1;
                                    req.raddr  = in_pos + IDX_W'(1);
                                    ptr_next   = in_pos + IDX_W'(1);
                                    state_next = ST_SHIFT;
                                end
                                else
                                begin
                                    count_next  = count_reg - CNT_W'(1);
                                    res_ok_next = 1'b1;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                req.re     = 1'b1;
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                res_val_next = '1;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                res_ok_next  = 1'b1;
                res_val_next = rdata;
                state_next   = ST_DONE;
            end
            ST_SHIFT:
            begin
                // write back the entry read last cycle one place nearer the head
                req.we    = 1'b1;
                req.waddr = ptr_reg - IDX_W'(1);
                req.wdata = rdata;
                if (({1'b0, ptr_reg} + CNT_W'(1)) < count_reg)
                begin
                    req.re    = 1'b1;
                    req.raddr = ptr_reg + IDX_W'(1);
                    ptr_next  = ptr_reg + IDX_W'(1);
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_val_next   = res_val_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        res_ok_reg  <= res_ok_next;
        res_val_reg <= res_val_next;
        out_ok_reg  <= out_ok_next;
        out_val_reg <= out_val_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_cnt_reg, out_val_reg};
    assign m_axis_tuser  = out_ok_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_op == OP_APPEND && count_reg < CNT_W'(CAPACITY))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the count");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.we && req.re && req.waddr == req.raddr))
        else $error("memory read and write hit the same entry");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> ({1'b0, ptr_reg} < count_reg && ptr_reg != '0))
        else $error("move-up walk outside held entries");

endmodule

[sv/ils_mem.sv]
// Value memory: one write port, one read port with registered read data.
module ils_mem
    import ils_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/testbench.sv]
// Testbench for indexed_list_store: directed and random list operations against a queue model.
`timescale 1ns / 1ps

module testbench
    import ils_pkg::*;
();

    localparam logic [1:0]               OP_UNKNOWN        = 2'd3;
    localparam logic signed [DATA_W-1:0] FAILED_READ       = -32'sd1;
    localparam int                       LONG_STALL_CYCLES = 300;
    localparam int                       DRAIN_CYCLES      = 40;
    localparam int                       CYCLE_LIMIT       = 1000000;
    localparam int                       STALL_FILL_WORDS  = 48;
    localparam int                       RANDOM_WORDS      = 320;
    localparam int                       QUIET_TAIL_WORDS  = 80;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [31:0] item_value, [41:32] position, rest zero
    logic [1:0]  s_axis_tuser;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] read_value, [42:32] entry_count, rest zero
    logic [0:0]  m_axis_tuser;   // [0] ok

    // Predicted list contents, head at index 0
    logic signed [DATA_W-1:0] list_entries[$];
    list_result_t             pending_results[$];

    int  error_count    = 0;
    int  results_seen   = 0;
    int  cycle_count    = 0;
    int  op_count[4]    = '{0, 0, 0, 0};
    int  full_rejects   = 0;
    int  range_failures = 0;
    bit  source_idle_on = 1'b0;
    bit  sink_idle_on   = 1'b0;
    bit  long_stall_req = 1'b0;

    indexed_list_store dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply one operation to the list model and return the result it should give
    function automatic list_result_t apply_list_op(logic [1:0] op,
                                                   logic signed [DATA_W-1:0] value,
                                                   logic [IDX_W-1:0] pos);
        list_result_t res;
        res.ok         = 1'b0;
        res.read_value = '0;
        case (op)
            OP_APPEND:
            begin
                if (list_entries.size() < CAPACITY)
                begin
                    list_entries.push_back(value);
                    res.ok = 1'b1;
                end
                else
                    full_rejects++;
            end
            OP_REMOVE:
            begin
                if (pos < list_entries.size())
                begin
                    list_entries.delete(pos);
                    res.ok = 1'b1;
                end
                else
                    range_failures++;
            end
            OP_READ:
            begin
                if (pos < list_entries.size())
                begin
                    res.read_value = list_entries[pos];
                    res.ok         = 1'b1;
                end
                else
                begin
                    res.read_value = FAILED_READ;
                    range_failures++;
                end
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(list_entries.size());
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, with an optional idle burst first; valid stays high on return
    task automatic send_word(logic [1:0] op, logic [DATA_W-1:0] value, logic [IDX_W-1:0] pos);
        int gap;
        if (source_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, pos, value};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_list_op(op, value, pos));
        op_count[op]++;
    endtask

    // Hold the source until every outstanding result has arrived
    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result sink: random idle bursts, plus one long hold-off on request
    initial
    begin : result_sink
        int burst;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES - 1) @(negedge clk);
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word: ok=%0b value=%0d count=%0d", $time,
                         m_axis_tuser[0], $signed(m_axis_tdata[31:0]), m_axis_tdata[42:32]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.ok
                    || m_axis_tdata[31:0] !== want.read_value
                    || m_axis_tdata[42:32] !== want.entry_count)
                begin
                    $display("%0t: mismatch: expected ok=%0b value=%0d count=%0d,",
                             $time, want.ok, want.read_value, want.entry_count);
                    $display("    got ok=%0b value=%0d count=%0d",
                             m_axis_tuser[0], $signed(m_axis_tdata[31:0]), m_axis_tdata[42:32]);
                    error_count++;
                end
            end
        end
    end

    // Reads and removes on an empty list, plus an unknown op
    task automatic test_empty_list();
        send_word(OP_READ, 32'h1234_5678, '0);
        send_word(OP_REMOVE, 32'h0, '0);
        send_word(OP_READ, 32'hFFFF_FFFF, '1);
        send_word(OP_REMOVE, 32'h0, '1);
        send_word(OP_UNKNOWN, 32'hFFFF_FFFF, '1);
    endtask

    // Extreme values, in-range and out-of-range positions, removes at head, middle, tail
    task automatic test_basic_ops();
        send_word(OP_APPEND, 32'h8000_0000, '1);
        send_word(OP_APPEND, 32'h7FFF_FFFF, '0);
        send_word(OP_APPEND, 32'hFFFF_FFFF, '0);
        send_word(OP_APPEND, 32'h0000_0000, '0);
        send_word(OP_APPEND, 32'h5555_5555, '0);
        send_word(OP_APPEND, 32'hAAAA_AAAA, '0);
        send_word(OP_READ, 32'h0, 10'd0);
        send_word(OP_READ, 32'h0, 10'd2);
        send_word(OP_READ, 32'h0, 10'd5);
        send_word(OP_READ, 32'h0, 10'd6);
        send_word(OP_REMOVE, 32'h0, 10'd2);
        send_word(OP_READ, 32'h0, 10'd2);
        send_word(OP_REMOVE, 32'h0, 10'd0);
        send_word(OP_REMOVE, 32'h0, 10'd3);
        send_word(OP_REMOVE, 32'h0, 10'd3);
        send_word(OP_READ, 32'h0, 10'd0);
        send_word(OP_UNKNOWN, 32'h5A5A_5A5A, 10'd1);
        send_word(OP_READ, 32'h0, 10'd1);
        wait_results_drained();
    endtask

    // Grow the list under a long sink hold-off, then walk it down with long and short removes
    task automatic test_sink_stall();
        int n;
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        for (int i = 0; i < STALL_FILL_WORDS; i++)
        begin
            if (i == 16)
                long_stall_req = 1'b1;
            send_word(OP_APPEND, random_value(), IDX_W'($urandom));
        end
        n = list_entries.size();
        send_word(OP_READ, 32'h0, '0);
        send_word(OP_READ, 32'h0, IDX_W'(n - 1));
        send_word(OP_READ, 32'h0, IDX_W'(n));
        send_word(OP_REMOVE, 32'h0, IDX_W'(n));
        send_word(OP_REMOVE, 32'h0, '0);
        send_word(OP_READ, 32'h0, '0);
        send_word(OP_REMOVE, 32'h0, '1);
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        while (list_entries.size() > 4)
        begin
            n = list_entries.size();
            if ($urandom_range(0, 2) == 0)
                send_word(OP_REMOVE, random_value(), '0);
            else
                send_word(OP_REMOVE, random_value(), IDX_W'($urandom_range(0, n - 1)));
        end
        wait_results_drained();
    endtask

    // Random mix kept at small list sizes so removes stay short
    task automatic test_random_ops();
        int          r;
        int          n;
        logic [1:0]  op;
        logic [IDX_W-1:0] pos;
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - QUIET_TAIL_WORDS)
            begin
                source_idle_on = 1'b0;
                sink_idle_on   = 1'b0;
            end
            if (i == RANDOM_WORDS / 2)
                wait_results_drained();
            n = list_entries.size();
            r = $urandom_range(0, 99);
            if (r < 5)
                op = OP_UNKNOWN;
            else if (r < (n > 80 ? 25 : 50))
                op = OP_APPEND;
            else if (r < 75)
                op = OP_REMOVE;
            else
                op = OP_READ;
            r = $urandom_range(0, 9);
            if (n > 0 && r < 8)
                pos = IDX_W'($urandom_range(0, n - 1));
            else if (r < 9)
                pos = IDX_W'($urandom_range(n, 1023));
            else
                pos = IDX_W'($urandom);
            send_word(op, random_value(), pos);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_APPEND;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_basic_ops();
        test_sink_stall();
        test_random_ops();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d appends, %0d removes, %0d reads, %0d unknown ops; %0d results checked.",
                 op_count[OP_APPEND], op_count[OP_REMOVE], op_count[OP_READ],
                 op_count[OP_UNKNOWN], results_seen);
        $display("Full-store rejects: %0d, out-of-range positions: %0d, mismatches: %0d.",
                 full_rejects, range_failures, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[indexed_list_store.f]
sv/ils_pkg.sv
sv/ils_mem.sv
sv/indexed_list_store.sv
tb/testbench.sv
